[rtl/pic_pkg.sv]
package pic_pkg;

    localparam int DEF_NUM_SOURCES = 64;
    localparam int DEF_PRIO_LEVELS = 16;

    typedef enum logic [2:0] {
        F_TRIGGER = 3'd0,
        F_DISABLE = 3'd1,
        F_ENABLE  = 3'd2,
        F_MASK    = 3'd3,
        F_UNMASK  = 3'd4,
        F_DONE    = 3'd5,
        F_SETPRIO = 3'd6,
        F_CLAIM   = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NONE    = 2'd1,
        ST_BADPRIO = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SS_IDLE    = 2'd0,
        SS_PENDING = 2'd1,
        SS_SERVICE = 2'd2
    } t_src_state;

    // classified command handed from front to back
    typedef enum logic [3:0] {
        K_NOP,
        K_TRIGGER,
        K_DISABLE,
        K_ENABLE,
        K_MASK,
        K_UNMASK,
        K_DONE,
        K_SETPRIO,
        K_BADPRIO,
        K_CLAIM
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MOD,
        S_SCAN,
        S_SCAN_LAST,
        S_CLAIM_WR,
        S_RESULT
    } t_bstate;

    typedef struct packed {
        logic [2:0] func;
        logic [5:0] source;
        logic [4:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] claimed_source;
        logic       irq_request;
    } t_out_item;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] src;
        logic [4:0] prio;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_cmdq;

endpackage

[rtl/priority_interrupt_controller.sv]
// Priority interrupt controller.
// Input queue: drive i_item and raise push while full is low; the item is
// taken at that clock edge. Items are device triggers or commands (disable,
// enable, mask, unmask, done, set priority, claim) on one source.
// Result queue: while empty is low, o_item holds the oldest result (status,
// claimed source, request line after the item); raise pop to take it.
// Every item gives exactly one result, in order.
// A front stage classifies items into a two-entry command queue; a back
// sequencer executes them against a one-port-read source record memory.
// A trigger or a plain command passes through the read, modify and result
// steps; a command on a source out of range or with a bad priority goes
// straight to the result step; a claim walks the record memory one source
// per cycle, then writes the claimed record and gives its result. Items are
// executed one at a time; the back takes the next once the last is through.
// Reset (synchronous, active low) makes every source disabled, unmasked,
// idle and without priority at once through per-source valid bits; no
// clearing pass is needed. If the result is not popped, the back stalls with
// the next result ready, and up to two further items are still accepted.
module priority_interrupt_controller
    import pic_pkg::*;
#(
    parameter int NUM_SOURCES = DEF_NUM_SOURCES,
    parameter int PRIO_LEVELS = DEF_PRIO_LEVELS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    t_cmdq cmd;
    logic  cmd_pop;

    pic_front #(
        .NUM_SOURCES (NUM_SOURCES),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    pic_back #(
        .NUM_SOURCES (NUM_SOURCES),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_cmd_pop (cmd_pop),
        .o_item    (o_item),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

[rtl/pic_ram.sv]
module pic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pic_front.sv]
module pic_front
    import pic_pkg::*;
#(
    parameter int NUM_SOURCES = DEF_NUM_SOURCES,
    parameter int PRIO_LEVELS = DEF_PRIO_LEVELS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output t_cmdq    o_cmd,
    input  logic     i_cmd_pop
);

    localparam int SW  = ($clog2(NUM_SOURCES + 1) > 6) ? $clog2(NUM_SOURCES + 1) : 6;
    localparam int PCW = ($clog2(PRIO_LEVELS + 1) > 5) ? $clog2(PRIO_LEVELS + 1) : 5;

    t_op        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       src_ok;
    logic       prio_ok;
    logic       accept;
    t_op        op_in;

    assign src_ok  = SW'(i_item.source) < SW'(NUM_SOURCES);
    assign prio_ok = PCW'(i_item.priority_req) < PCW'(PRIO_LEVELS);

    always_comb begin
        op_in.src  = i_item.source;
        op_in.prio = i_item.priority_req;
        op_in.kind = K_NOP;
        if (t_func'(i_item.func) == F_CLAIM) begin
            op_in.kind = K_CLAIM;
        end else if (src_ok) begin
            case (t_func'(i_item.func))
                F_TRIGGER: op_in.kind = K_TRIGGER;
                F_DISABLE: op_in.kind = K_DISABLE;
                F_ENABLE:  op_in.kind = K_ENABLE;
                F_MASK:    op_in.kind = K_MASK;
                F_UNMASK:  op_in.kind = K_UNMASK;
                F_DONE:    op_in.kind = K_DONE;
                F_SETPRIO: op_in.kind = prio_ok ? K_SETPRIO : K_BADPRIO;
                default:   op_in.kind = K_NOP;
            endcase
        end
    end

    assign o_full = (r_cnt == 2'd2);
    assign accept = i_push && !o_full;

    always_comb begin
        n_cnt = r_cnt;
        if (accept && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!accept && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= op_in;
        end
    end

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.op    = r_q[r_rp];

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("front queue count out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_cnt != 2'd0))
        else $error("front queue popped while empty");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_cmd_pop) |=> o_full)
        else $error("front queue left full without a pop");

endmodule

[rtl/pic_back.sv]
module pic_back
    import pic_pkg::*;
#(
    parameter int NUM_SOURCES = DEF_NUM_SOURCES,
    parameter int PRIO_LEVELS = DEF_PRIO_LEVELS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmdq     i_cmd,
    output logic      o_cmd_pop,
    output t_out_item o_item,
    output logic      o_empty,
    input  logic      i_pop
);

    localparam int IW    = $clog2(NUM_SOURCES);
    localparam int PW    = $clog2(PRIO_LEVELS + 1);
    localparam int CW    = $clog2(NUM_SOURCES + 1);
    localparam int XW    = (IW > 6) ? IW : 6;
    localparam int REC_W = PW + 4;

    // record layout: {prio, state, mask, enable}
    localparam logic [REC_W-1:0] RESET_REC = {PW'(PRIO_LEVELS), SS_IDLE, 1'b0, 1'b0};

    t_bstate          r_state;
    t_bstate          n_state;
    t_op              r_cmd;
    logic [IW-1:0]    r_idx;
    logic             r_pv;
    logic [IW-1:0]    r_pidx;
    logic [IW-1:0]    r_best_idx;
    logic [PW-1:0]    r_best_prio;
    logic             r_found;
    t_status          r_status;
    logic [5:0]       r_claim;
    logic [CW-1:0]    r_live_cnt;
    logic [NUM_SOURCES-1:0] r_vld;
    logic             r_rd_vld;
    t_out_item        r_out;
    logic             r_out_vld;

    logic [XW-1:0]    cmd_src_x;
    logic [IW-1:0]    cmd_idx;
    logic [XW-1:0]    best_x;
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [REC_W-1:0] ram_wdata;
    logic [IW-1:0]    ram_raddr;
    logic [REC_W-1:0] ram_rdata;
    logic [REC_W-1:0] rd_rec;
    logic             rd_en;
    logic             rd_mask;
    logic [1:0]       rd_st;
    logic [PW-1:0]    rd_prio;
    logic             nw_en;
    logic             nw_mask;
    logic [1:0]       nw_st;
    logic [PW-1:0]    nw_prio;
    logic             old_live;
    logic             new_live;
    logic             chk;
    logic             out_free;

    function automatic logic is_live(input logic en, input logic mask, input logic [1:0] st);
        return en && !mask && (st == SS_PENDING);
    endfunction

    assign cmd_src_x = XW'(r_cmd.src);
    assign cmd_idx   = cmd_src_x[IW-1:0];
    assign best_x    = XW'(r_best_idx);

    pic_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_SOURCES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // never-written entries read as the reset record
    assign rd_rec  = r_rd_vld ? ram_rdata : RESET_REC;
    assign rd_en   = rd_rec[0];
    assign rd_mask = rd_rec[1];
    assign rd_st   = rd_rec[3:2];
    assign rd_prio = rd_rec[REC_W-1:4];

    always_comb begin
        nw_en   = rd_en;
        nw_mask = rd_mask;
        nw_st   = rd_st;
        nw_prio = rd_prio;
        case (r_cmd.kind)
            K_TRIGGER: if (rd_en) begin
                nw_st = SS_PENDING;
            end
            K_DISABLE: nw_en   = 1'b0;
            K_ENABLE:  nw_en   = 1'b1;
            K_MASK:    nw_mask = 1'b1;
            K_UNMASK:  nw_mask = 1'b0;
            K_DONE:    nw_st   = SS_IDLE;
            K_SETPRIO: nw_prio = PW'(r_cmd.prio);
            default:   nw_en   = rd_en;
        endcase
    end

    assign old_live = is_live(rd_en, rd_mask, rd_st);
    assign new_live = is_live(nw_en, nw_mask, nw_st);
    assign chk      = r_pv && ((r_state == S_SCAN) || (r_state == S_SCAN_LAST));
    assign out_free = !r_out_vld || i_pop;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_cmd.valid) begin
                case (i_cmd.op.kind)
                    K_CLAIM:   n_state = S_SCAN;
                    K_NOP:     n_state = S_RESULT;
                    K_BADPRIO: n_state = S_RESULT;
                    default:   n_state = S_RD;
                endcase
            end
            S_RD:        n_state = S_MOD;
            S_MOD:       n_state = S_RESULT;
            S_SCAN:      if (r_idx == IW'(NUM_SOURCES - 1)) begin
                n_state = S_SCAN_LAST;
            end
            S_SCAN_LAST: n_state = S_CLAIM_WR;
            S_CLAIM_WR:  n_state = S_RESULT;
            S_RESULT:    if (out_free) begin
                n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cmd_idx;
        ram_wdata = {nw_prio, nw_st, nw_mask, nw_en};
        ram_raddr = cmd_idx;
        case (r_state)
            S_IDLE:     o_cmd_pop = i_cmd.valid;
            S_SCAN:     ram_raddr = r_idx;
            S_MOD:      ram_we    = 1'b1;
            S_CLAIM_WR: begin
                ram_we    = r_found;
                ram_waddr = r_best_idx;
                ram_wdata = {r_best_prio, SS_SERVICE, 1'b0, 1'b1};
            end
            default:    ram_we    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_live_cnt <= '0;
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_pv       <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_SCAN);
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (r_state == S_IDLE && i_cmd.valid) begin
                r_found <= 1'b0;
            end else if (chk && is_live(rd_en, rd_mask, rd_st) && rd_prio < r_best_prio) begin
                r_found <= 1'b1;
            end
            if (r_state == S_MOD && new_live && !old_live) begin
                r_live_cnt <= r_live_cnt + CW'(1);
            end else if (r_state == S_MOD && old_live && !new_live) begin
                r_live_cnt <= r_live_cnt - CW'(1);
            end else if (r_state == S_CLAIM_WR && r_found) begin
                r_live_cnt <= r_live_cnt - CW'(1);
            end
            if (r_state == S_RESULT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[ram_raddr];
        r_pidx   <= r_idx;
        if (r_state == S_IDLE && i_cmd.valid) begin
            r_cmd       <= i_cmd.op;
            r_idx       <= '0;
            r_best_idx  <= '0;
            r_best_prio <= PW'(PRIO_LEVELS);
            r_claim     <= '0;
            r_status    <= (i_cmd.op.kind == K_BADPRIO) ? ST_BADPRIO : ST_OK;
        end
        if (r_state == S_SCAN) begin
            r_idx <= r_idx + IW'(1);
        end
        if (chk && is_live(rd_en, rd_mask, rd_st) && rd_prio < r_best_prio) begin
            r_best_prio <= rd_prio;
            r_best_idx  <= r_pidx;
        end
        if (r_state == S_CLAIM_WR) begin
            if (r_found) begin
                r_claim <= best_x[5:0];
            end else begin
                r_status <= ST_NONE;
            end
        end
        if (r_state == S_RESULT && out_free) begin
            r_out.status         <= r_status;
            r_out.claimed_source <= r_claim;
            r_out.irq_request    <= (r_live_cnt != '0);
        end
    end

    assign o_item  = r_out;
    assign o_empty = !r_out_vld;

    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live_cnt <= CW'(NUM_SOURCES))
        else $error("live source count exceeds source count");

    a_claim_drops_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAIM_WR && r_found) |=> (r_live_cnt == $past(r_live_cnt) - CW'(1)))
        else $error("claim did not retire a live source");

    a_found_prio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAIM_WR && r_found) |-> (r_best_prio < PW'(PRIO_LEVELS)))
        else $error("claimed source has an unset priority");

    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_MOD || r_state == S_CLAIM_WR))
        else $error("record written outside a modify or claim step");

endmodule
